FILE: sv/ipr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipr_pkg - shared types and constants for the incremental PI regulator
// Register map, configuration record, widths and reset values.
// ----------------------------------------------------------------------------
package ipr_pkg;

  // Fixed field widths
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned LIMIT_W   = 15;
  localparam int unsigned DZ_W      = 9;
  localparam int unsigned SEP_W     = 16;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned ACC_W     = LIMIT_W + FRAC_BITS;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 3;

  // Reset values
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 16'd4096;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 16'd205;
  localparam logic [LIMIT_W-1:0] OUT_LOW_RST     = 15'd0;
  localparam logic [LIMIT_W-1:0] OUT_HIGH_RST    = 15'd25600;
  localparam logic [DZ_W-1:0]    DEAD_ZONE_RST   = 9'd82;
  localparam logic [SEP_W-1:0]   SEPARATION_RST  = 16'd410;

  // Dead zone saturates here on write
  localparam logic [DZ_W-1:0]    DEAD_ZONE_MAX   = 9'd410;

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_OUT_LOW     = 3'd2,
    REG_OUT_HIGH    = 3'd3,
    REG_DEAD_ZONE   = 3'd4,
    REG_SEPARATION  = 3'd5
  } reg_index_t;

  // Configuration record shared by the datapath stages
  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [LIMIT_W-1:0] out_low_limit;
    logic [LIMIT_W-1:0] out_high_limit;
    logic [DZ_W-1:0]    dead_zone;
    logic [SEP_W-1:0]   separation_limit;
  } cfg_t;

endpackage

FILE: sv/ipr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipr_in_if - sample channel
// Valid/ready channel carrying a target and a measured pressure.
// ----------------------------------------------------------------------------
interface ipr_in_if #(
  parameter int unsigned PRESSURE_BITS = 16
);
  logic                     valid;
  logic                     ready;
  logic [PRESSURE_BITS-1:0] target_pressure;
  logic [PRESSURE_BITS-1:0] measured_pressure;

  modport source (output valid, output target_pressure, output measured_pressure,
                  input ready);
  modport sink   (input valid, input target_pressure, input measured_pressure,
                  output ready);
endinterface

FILE: sv/ipr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipr_out_if - drive result channel
// Valid/ready channel carrying the clamped drive level.
// ----------------------------------------------------------------------------
interface ipr_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] drive_level;

  modport source (output valid, output drive_level, input ready);
  modport sink   (input valid, input drive_level, output ready);
endinterface

FILE: sv/ipr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipr_cfg_regs - configuration register file
// Holds gains, limits and thresholds; flags a dynamics clear after any
// write to a known register.
// ----------------------------------------------------------------------------
module ipr_cfg_regs import ipr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg,
  output logic                   dyn_clear
);

  logic [DZ_W-1:0] dz_sat;
  logic            known_index;

  // Dead zone saturation and index decode
  always_comb begin
    dz_sat = (cfg_data[DZ_W-1:0] > DEAD_ZONE_MAX) ? DEAD_ZONE_MAX : cfg_data[DZ_W-1:0];
    unique case (reg_index_t'(cfg_index))
      REG_PROP_GAIN, REG_INTEG_GAIN, REG_OUT_LOW,
      REG_OUT_HIGH, REG_DEAD_ZONE, REG_SEPARATION: known_index = 1'b1;
      default:                                     known_index = 1'b0;
    endcase
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain        <= PROP_GAIN_RST;
      cfg.integ_gain       <= INTEG_GAIN_RST;
      cfg.out_low_limit    <= OUT_LOW_RST;
      cfg.out_high_limit   <= OUT_HIGH_RST;
      cfg.dead_zone        <= DEAD_ZONE_RST;
      cfg.separation_limit <= SEPARATION_RST;
      dyn_clear            <= 1'b0;
    end else begin
      dyn_clear <= cfg_write && known_index;
      if (cfg_write) begin
        unique case (reg_index_t'(cfg_index))
          REG_PROP_GAIN:  cfg.prop_gain        <= cfg_data[GAIN_W-1:0];
          REG_INTEG_GAIN: cfg.integ_gain       <= cfg_data[GAIN_W-1:0];
          REG_OUT_LOW:    cfg.out_low_limit    <= cfg_data[LIMIT_W-1:0];
          REG_OUT_HIGH:   cfg.out_high_limit   <= cfg_data[LIMIT_W-1:0];
          REG_DEAD_ZONE:  cfg.dead_zone        <= dz_sat;
          REG_SEPARATION: cfg.separation_limit <= cfg_data[SEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Dead zone never leaves its legal range
  a_dz_range: assert property (@(posedge clk) disable iff (rst)
    cfg.dead_zone <= DEAD_ZONE_MAX)
    else $error("dead zone above saturation value");

endmodule

FILE: sv/ipr_err_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipr_err_stage - error input register
// Forms the raw error, applies deadband and integral separation and
// registers the raw error together with the integral product.
// ----------------------------------------------------------------------------
module ipr_err_stage import ipr_pkg::*; #(
  parameter int unsigned PRESSURE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          take,
  input  logic [PRESSURE_BITS-1:0]      target_pressure,
  input  logic [PRESSURE_BITS-1:0]      measured_pressure,
  input  logic                          advance,
  output logic                          a_valid,
  output logic signed [PRESSURE_BITS:0] a_raw,
  output logic signed [PRESSURE_BITS+17:0] a_integ
);

  localparam int unsigned MW = PRESSURE_BITS + 1;
  localparam int unsigned CW = (MW > SEP_W) ? MW : SEP_W;

  logic signed [PRESSURE_BITS:0]    raw;
  logic        [PRESSURE_BITS:0]    mag;
  logic                             in_dead;
  logic                             in_sep;
  logic signed [PRESSURE_BITS+17:0] integ_prod;

  // Raw error, magnitude and integral term
  always_comb begin
    raw        = $signed({1'b0, target_pressure}) - $signed({1'b0, measured_pressure});
    mag        = raw[PRESSURE_BITS] ? -raw : raw;
    in_dead    = mag <= MW'(cfg.dead_zone);
    in_sep     = CW'(mag) <= CW'(cfg.separation_limit);
    integ_prod = $signed({1'b0, cfg.integ_gain}) * raw;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (take) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_raw   <= raw;
      a_integ <= (!in_dead && in_sep) ? integ_prod : '0;
    end
  end

endmodule

FILE: sv/ipr_acc_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipr_acc_stage - accumulator and result register
// Adds the proportional and integral terms to the drive accumulator,
// clamps to the output limits and presents the drive level.
// ----------------------------------------------------------------------------
module ipr_acc_stage import ipr_pkg::*; #(
  parameter int unsigned PRESSURE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cfg_t                             cfg,
  input  logic                             dyn_clear,
  input  logic                             load,
  input  logic signed [PRESSURE_BITS:0]    a_raw,
  input  logic signed [PRESSURE_BITS+17:0] a_integ,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [LIMIT_W-1:0]               drive_level
);

  localparam int unsigned SW = (PRESSURE_BITS + 21 > 34) ? PRESSURE_BITS + 21 : 34;

  logic signed [PRESSURE_BITS:0]    prev_error;
  logic        [ACC_W-1:0]          acc;
  logic        [ACC_W-1:0]          acc_next;
  logic signed [PRESSURE_BITS+1:0]  diff;
  logic signed [PRESSURE_BITS+18:0] prop;
  logic signed [SW-1:0]             sum;
  logic signed [SW-1:0]             hi_ext;
  logic signed [SW-1:0]             lo_ext;
  logic signed [SW-1:0]             acc_ext;

  // Velocity-form update with clamp; high limit checked first
  always_comb begin
    diff    = $signed({a_raw[PRESSURE_BITS], a_raw})
            - $signed({prev_error[PRESSURE_BITS], prev_error});
    prop    = $signed({1'b0, cfg.prop_gain}) * diff;
    acc_ext = SW'(acc);
    hi_ext  = SW'({cfg.out_high_limit, {FRAC_BITS{1'b0}}});
    lo_ext  = SW'({cfg.out_low_limit, {FRAC_BITS{1'b0}}});
    sum     = acc_ext + SW'(prop) + SW'(a_integ);
    priority if (sum > hi_ext) begin
      acc_next = {cfg.out_high_limit, {FRAC_BITS{1'b0}}};
    end else if (sum < lo_ext) begin
      acc_next = {cfg.out_low_limit, {FRAC_BITS{1'b0}}};
    end else begin
      acc_next = sum[ACC_W-1:0];
    end
  end

  // Regulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
      acc        <= {OUT_LOW_RST, {FRAC_BITS{1'b0}}};
    end else if (dyn_clear) begin
      prev_error <= '0;
      acc        <= {cfg.out_low_limit, {FRAC_BITS{1'b0}}};
    end else if (load) begin
      prev_error <= a_raw;
      acc        <= acc_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive_level <= acc_next[ACC_W-1:FRAC_BITS];
    end
  end

  // Accumulator only moves on a transfer or a clear
  a_acc_hold: assert property (@(posedge clk) disable iff (rst)
    !load && !dyn_clear |=> $stable(acc) && $stable(prev_error))
    else $error("accumulator changed without transfer");

  // A transfer always produces a result next cycle
  a_load_result: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("result missing after transfer");

  // Presented drive never exceeds the larger of the two limits
  a_drive_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive_level <= cfg.out_high_limit || drive_level <= cfg.out_low_limit))
    else $error("drive level outside limits");

endmodule

FILE: sv/incremental_pi_regulator_top.sv
`timescale 1ns / 1ps
// Path: sample register, then result register; a stalled result holds the sample in the sample register.
// Throughput: one sample per cycle unless the result channel stalls; the add and clamp are combinational.
// Reset (rst, synchronous): registers to defaults, error history zero,
// accumulator at the low limit, both pipeline stages empty.
// Any write to a known register clears error history and reloads the low limit.
// ----------------------------------------------------------------------------
// incremental_pi_regulator_top - velocity-form PI pressure regulator
// Sample register, accumulator stage and configuration registers.
// ----------------------------------------------------------------------------
module incremental_pi_regulator_top import ipr_pkg::*; #(
  parameter int unsigned PRESSURE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  ipr_in_if.sink                 sample,
  ipr_out_if.source              result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t                             cfg;
  logic                             dyn_clear;
  logic                             a_valid;
  logic signed [PRESSURE_BITS:0]    a_raw;
  logic signed [PRESSURE_BITS+17:0] a_integ;
  logic                             load;
  logic                             take;

  // Pipeline flow control
  assign load         = a_valid && (!result.valid || result.ready);
  assign sample.ready = !a_valid || load;
  assign take         = sample.valid && sample.ready;

  ipr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .dyn_clear (dyn_clear)
  );

  ipr_err_stage #(.PRESSURE_BITS(PRESSURE_BITS)) u_err (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .take              (take),
    .target_pressure   (sample.target_pressure),
    .measured_pressure (sample.measured_pressure),
    .advance           (load),
    .a_valid           (a_valid),
    .a_raw             (a_raw),
    .a_integ           (a_integ)
  );

  ipr_acc_stage #(.PRESSURE_BITS(PRESSURE_BITS)) u_acc (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .dyn_clear   (dyn_clear),
    .load        (load),
    .a_raw       (a_raw),
    .a_integ     (a_integ),
    .out_ready   (result.ready),
    .out_valid   (result.valid),
    .drive_level (result.drive_level)
  );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the incremental PI pressure regulator
// Drives pressure samples through the valid/ready input channel and checks
// every drive level against a cycle-free velocity-form PI predictor that
// tracks the error history, accumulator and register settings. The bench
// covers directed corner cases, register writes, crossed and out-of-range
// limits and long random runs under random and forced backpressure.
// ----------------------------------------------------------------------------
module tb_top;
  import ipr_pkg::*;

  localparam int unsigned PB = 16;
  // Indexes outside the register map, writes there must be ignored
  localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_HI = 3'd7;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned STALL_CYCLES   = 60;
  localparam int unsigned MAX_LOG_LINES  = 100;

  logic clk = 1'b0;
  logic rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  ipr_in_if #(.PRESSURE_BITS(PB)) sample_ch ();
  ipr_out_if                      result_ch ();

  incremental_pi_regulator_top #(.PRESSURE_BITS(PB)) uut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Regulator model: settings, error history and drive accumulator
  cfg_t               cfg_model;
  logic signed [16:0] last_error;
  longint             drive_acc;

  logic [14:0] pending_drive[$];
  int unsigned fail_count    = 0;
  int unsigned results_seen  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_reqs    = 0;
  int unsigned stall_len     = 0;
  int unsigned stall_seen    = 0;
  int unsigned hold_left     = 0;

  task automatic report_mismatch(string what, logic [14:0] want, logic [14:0] got);
    if (fail_count < MAX_LOG_LINES)
      $display("MISMATCH %s: result %0d expected %0d got %0d at %0t",
               what, results_seen, want, got, $time);
    fail_count++;
  endtask

  function automatic void clear_history();
    last_error = '0;
    drive_acc  = cfg_model.out_low_limit;
    drive_acc  = drive_acc * 65536;
  endfunction

  function automatic void reset_model();
    cfg_model.prop_gain        = PROP_GAIN_RST;
    cfg_model.integ_gain       = INTEG_GAIN_RST;
    cfg_model.out_low_limit    = OUT_LOW_RST;
    cfg_model.out_high_limit   = OUT_HIGH_RST;
    cfg_model.dead_zone        = DEAD_ZONE_RST;
    cfg_model.separation_limit = SEPARATION_RST;
    clear_history();
  endfunction

  // Register write: unknown indexes leave everything untouched
  function automatic void apply_reg_write(logic [CFG_INDEX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
    logic known;
    known = 1'b1;
    case (idx)
      REG_PROP_GAIN:  cfg_model.prop_gain        = data;
      REG_INTEG_GAIN: cfg_model.integ_gain       = data;
      REG_OUT_LOW:    cfg_model.out_low_limit    = data[14:0];
      REG_OUT_HIGH:   cfg_model.out_high_limit   = data[14:0];
      REG_DEAD_ZONE:  cfg_model.dead_zone        =
                        (data[8:0] > DEAD_ZONE_MAX) ? DEAD_ZONE_MAX : data[8:0];
      REG_SEPARATION: cfg_model.separation_limit = data;
      default:        known = 1'b0;
    endcase
    if (known) clear_history();
  endfunction

  // One regulator step: P on error change, I on deadbanded error, then clamp
  function automatic logic [14:0] next_drive_level(logic [PB-1:0] tgt,
                                                   logic [PB-1:0] meas);
    longint r, e, mag, delta, lo, hi, dz, sep, kp, ki, prev;
    r    = $signed({1'b0, tgt}) - $signed({1'b0, meas});
    prev = last_error;
    dz   = cfg_model.dead_zone;
    sep  = cfg_model.separation_limit;
    kp   = cfg_model.prop_gain;
    ki   = cfg_model.integ_gain;
    lo   = cfg_model.out_low_limit;
    hi   = cfg_model.out_high_limit;
    lo   = lo * 65536;
    hi   = hi * 65536;
    e     = (r >= -dz && r <= dz) ? 0 : r;
    delta = kp * (r - prev);
    mag   = (e < 0) ? -e : e;
    if (mag <= sep) delta += ki * e;
    drive_acc += delta;
    // high limit checked first, so it wins when the limits cross
    if (drive_acc > hi)      drive_acc = hi;
    else if (drive_acc < lo) drive_acc = lo;
    last_error = r[16:0];
    return drive_acc[30:16];
  endfunction

  // Result receiver: random ready, plus long hold-offs on request
  always @(posedge clk) begin
    if (stall_reqs != stall_seen) begin
      stall_seen = stall_reqs;
      hold_left  = stall_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: each transfer against the oldest prediction
  always @(posedge clk) begin
    logic [14:0] want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_seen++;
      if (pending_drive.size() == 0) begin
        report_mismatch("unexpected result", '0, result_ch.drive_level);
      end else begin
        want = pending_drive.pop_front();
        if (result_ch.drive_level !== want)
          report_mismatch("drive_level", want, result_ch.drive_level);
      end
    end
  end

  // Offer one sample, with a random gap first; valid stays high on return
  task automatic send_sample(logic [PB-1:0] tgt, logic [PB-1:0] meas);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    sample_ch.valid             <= 1'b1;
    sample_ch.target_pressure   <= tgt;
    sample_ch.measured_pressure <= meas;
    do @(posedge clk); while (!sample_ch.ready);
    pending_drive.push_back(next_drive_level(tgt, meas));
  endtask

  // Stop offering and wait for every predicted result
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg_write(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic restore_defaults();
    drain_results();
    write_reg(REG_PROP_GAIN,  PROP_GAIN_RST);
    write_reg(REG_INTEG_GAIN, INTEG_GAIN_RST);
    write_reg(REG_OUT_LOW,    CFG_DATA_W'(OUT_LOW_RST));
    write_reg(REG_OUT_HIGH,   CFG_DATA_W'(OUT_HIGH_RST));
    write_reg(REG_DEAD_ZONE,  CFG_DATA_W'(DEAD_ZONE_RST));
    write_reg(REG_SEPARATION, SEPARATION_RST);
  endtask

  function automatic logic [15:0] pick_setting(int unsigned typ_max);
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(typ_max));
    endcase
  endfunction

  // New random settings, extremes included, written while idle
  task automatic shuffle_settings();
    logic [15:0] lo, hi;
    drain_results();
    lo = 16'($urandom_range(6400));
    case ($urandom_range(7))
      0:       hi = 16'($urandom_range(lo));        // crossed or equal limits
      1:       hi = 16'hFFFF;                       // above range, bit 15 dropped
      2:       hi = 16'd25600;
      default: hi = 16'($urandom_range(25600, lo));
    endcase
    write_reg(REG_PROP_GAIN,  pick_setting(8192));
    write_reg(REG_INTEG_GAIN, pick_setting(2048));
    write_reg(REG_OUT_HIGH,   hi);
    write_reg(REG_DEAD_ZONE,  pick_setting(511));
    write_reg(REG_SEPARATION, pick_setting(2000));
    // low limit last so some runs start from it with full history cleared
    write_reg(REG_OUT_LOW,    ($urandom_range(15) == 0) ? 16'd25600 : lo);
  endtask

  // Error values aimed at the deadband and separation edges
  function automatic int pick_error();
    int dz, sep, sgn;
    dz  = cfg_model.dead_zone;
    sep = cfg_model.separation_limit;
    sgn = $urandom_range(1) ? 1 : -1;
    case ($urandom_range(5))
      0:       return int'($urandom_range(2 * dz)) - dz;
      1:       return sgn * (dz + int'($urandom_range(2)) - 1);
      2:       return sgn * (sep + int'($urandom_range(2)) - 1);
      3:       return int'($urandom_range(4000)) - 2000;
      4:       return int'($urandom_range(131070)) - 65535;
      default: return int'($urandom_range(800)) - 400;
    endcase
  endfunction

  // Fixed setpoint with a measurement that settles towards it
  task automatic run_sequence(int unsigned len);
    int tgt, meas, e;
    tgt = $urandom_range(65535);
    e   = pick_error();
    repeat (len) begin
      meas = tgt - e;
      if (meas < 0)     meas = 0;
      if (meas > 65535) meas = 65535;
      send_sample(tgt[15:0], meas[15:0]);
      if ($urandom_range(9) == 0) e = pick_error();
      else e = e - e / 4 + int'($urandom_range(64)) - 32;
    end
  endtask

  task automatic run_noise(int unsigned len);
    repeat (len) send_sample(16'($urandom_range(65535)), 16'($urandom_range(65535)));
  endtask

  // Defaults after reset: deadband and separation edges
  task automatic test_reset_defaults();
    send_sample(16'd1000, 16'd1000);
    send_sample(16'd1082, 16'd1000);
    send_sample(16'd1083, 16'd1000);
    send_sample(16'd1000, 16'd1082);
    send_sample(16'd1000, 16'd1083);
    send_sample(16'd1410, 16'd1000);
    send_sample(16'd1411, 16'd1000);
    send_sample(16'd1000, 16'd1411);
  endtask

  task automatic test_field_extremes();
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'h0000, 16'h0000);
  endtask

  task automatic test_register_writes();
    // full-scale gains drive both clamps
    drain_results();
    write_reg(REG_PROP_GAIN,  16'hFFFF);
    write_reg(REG_INTEG_GAIN, 16'hFFFF);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'hFFFF, 16'h0000);
    // zero gains hold the output
    drain_results();
    write_reg(REG_PROP_GAIN,  16'h0000);
    write_reg(REG_INTEG_GAIN, 16'h0000);
    send_sample(16'd40000, 16'd100);
    // masked upper bits, limit above range, deadband saturation
    drain_results();
    write_reg(REG_PROP_GAIN,  PROP_GAIN_RST);
    write_reg(REG_INTEG_GAIN, INTEG_GAIN_RST);
    write_reg(REG_OUT_HIGH,   16'hFFFF);
    write_reg(REG_DEAD_ZONE,  16'hFFFF);
    write_reg(REG_SEPARATION, 16'hFFFF);
    write_reg(REG_OUT_LOW,    16'h8000 | 16'd25600);
    send_sample(16'd1000, 16'd999);
    // zero deadband, zero separation, zero-width output
    drain_results();
    write_reg(REG_DEAD_ZONE,  16'h0000);
    write_reg(REG_SEPARATION, 16'h0000);
    write_reg(REG_OUT_HIGH,   16'h0000);
    write_reg(REG_OUT_LOW,    16'h0000);
    send_sample(16'd2000, 16'd1000);
    // nine-bit maximum saturates too
    drain_results();
    write_reg(REG_OUT_HIGH,  16'd25600);
    write_reg(REG_DEAD_ZONE, 16'h01FF);
    send_sample(16'd1300, 16'd1000);
    // writes outside the map keep error history and accumulator
    send_sample(16'd30000, 16'd20000);
    drain_results();
    write_reg(SPARE_INDEX_LO, 16'hFFFF);
    write_reg(SPARE_INDEX_HI, 16'h1234);
    send_sample(16'd30000, 16'd20100);
  endtask

  task automatic test_crossed_limits();
    drain_results();
    write_reg(REG_OUT_HIGH, 16'd5000);
    write_reg(REG_OUT_LOW,  16'd20000);
    send_sample(16'd1000, 16'd1000);
    send_sample(16'd0,    16'd60000);
  endtask

  // Long receiver hold-off with the sender pushing flat out
  task automatic test_backpressure();
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_len     = STALL_CYCLES;
    stall_reqs++;
    run_sequence(16);
    run_noise(8);
    drain_results();
  endtask

  task automatic test_random_phase(int unsigned items, int unsigned s_pct,
                                   int unsigned r_pct);
    int unsigned start, next_shuffle;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    start         = pending_drive.size() + results_seen;
    next_shuffle  = start + 60;
    while (pending_drive.size() + results_seen < start + items) begin
      if (pending_drive.size() + results_seen >= next_shuffle) begin
        shuffle_settings();
        next_shuffle = pending_drive.size() + results_seen + $urandom_range(40, 120);
      end
      if ($urandom_range(99) < 85) run_sequence($urandom_range(24, 4));
      else run_noise($urandom_range(6, 1));
    end
  endtask

  // Stimulus sequence
  initial begin
    rst                         <= 1'b1;
    cfg_write                   <= 1'b0;
    cfg_index                   <= REG_PROP_GAIN;
    cfg_data                    <= '0;
    sample_ch.valid             <= 1'b0;
    sample_ch.target_pressure   <= '0;
    sample_ch.measured_pressure <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    reset_model();

    send_idle_pct = 28;
    recv_idle_pct = 70;
    test_reset_defaults();
    test_field_extremes();
    test_register_writes();
    test_crossed_limits();
    restore_defaults();

    test_random_phase(370, 28, 70);
    test_backpressure();
    test_random_phase(370, 70, 28);
    test_random_phase(370, 0, 0);
    drain_results();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: filelist.f
sv/ipr_pkg.sv
sv/ipr_in_if.sv
sv/ipr_out_if.sv
sv/ipr_cfg_regs.sv
sv/ipr_err_stage.sv
sv/ipr_acc_stage.sv
sv/incremental_pi_regulator_top.sv
tb/sv/tb_top.sv
